FILE: design/tlca_pkg.sv
// Shared types, constants and step codes for the tree ancestor block.
package tlca_pkg;

	localparam int NODE_SLOTS = 1024;
	localparam int EDGE_SLOTS = 2 * NODE_SLOTS;
	localparam int NW = $clog2(NODE_SLOTS);
	localparam int EIW = $clog2(EDGE_SLOTS);
	localparam int LW = EIW + 1;
	localparam int UW = 6;

	// Operation codes.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_BUILD = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;
	localparam logic [1:0] ST_BAD_NODE = 2'd3;

	// Step codes: controller states, also the datapath micro-operation.
	localparam logic [UW-1:0] S_IDLE = 6'd0;
	localparam logic [UW-1:0] S_HSWEEP = 6'd1;
	localparam logic [UW-1:0] S_E0 = 6'd2;
	localparam logic [UW-1:0] S_E1 = 6'd3;
	localparam logic [UW-1:0] S_E2 = 6'd4;
	localparam logic [UW-1:0] S_E3 = 6'd5;
	localparam logic [UW-1:0] S_BCHK = 6'd6;
	localparam logic [UW-1:0] S_BSWEEP = 6'd7;
	localparam logic [UW-1:0] S_B1INIT = 6'd8;
	localparam logic [UW-1:0] S_B1HEAD = 6'd9;
	localparam logic [UW-1:0] S_B1TOP = 6'd10;
	localparam logic [UW-1:0] S_B1EDGE = 6'd11;
	localparam logic [UW-1:0] S_B1CHK = 6'd12;
	localparam logic [UW-1:0] S_B1POP0 = 6'd13;
	localparam logic [UW-1:0] S_B1POP1 = 6'd14;
	localparam logic [UW-1:0] S_B1POP2 = 6'd15;
	localparam logic [UW-1:0] S_B1POP3 = 6'd16;
	localparam logic [UW-1:0] S_B2INIT = 6'd17;
	localparam logic [UW-1:0] S_B2HEAD = 6'd18;
	localparam logic [UW-1:0] S_B2TOP = 6'd19;
	localparam logic [UW-1:0] S_B2EDGE = 6'd20;
	localparam logic [UW-1:0] S_B2CHK = 6'd21;
	localparam logic [UW-1:0] S_B2POP0 = 6'd22;
	localparam logic [UW-1:0] S_B2POP1 = 6'd23;
	localparam logic [UW-1:0] S_B2POP2 = 6'd24;
	localparam logic [UW-1:0] S_Q0 = 6'd25;
	localparam logic [UW-1:0] S_Q1 = 6'd26;
	localparam logic [UW-1:0] S_Q2 = 6'd27;
	localparam logic [UW-1:0] S_QL0 = 6'd28;
	localparam logic [UW-1:0] S_QL1 = 6'd29;
	localparam logic [UW-1:0] S_QL2 = 6'd30;
	localparam logic [UW-1:0] S_QL3 = 6'd31;
	localparam logic [UW-1:0] S_QL4 = 6'd32;
	localparam logic [UW-1:0] S_QL5 = 6'd33;
	localparam logic [UW-1:0] S_QF0 = 6'd34;
	localparam logic [UW-1:0] S_QF1 = 6'd35;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic [UW-1:0] uop;
		logic load;
		logic finish;
		logic [1:0] status;
	} cmd_t;

	// Status flags from the datapath to the controller.
	typedef struct packed {
		logic a_zero;
		logic b_zero;
		logic full;
		logic built;
		logic sweep_last;
		logic c_zero;
		logic sp_one;
		logic fresh;
		logic p2_ok;
		logic depth_zero;
		logic same_chain;
	} flags_t;

endpackage

FILE: design/tlca_ctrl.sv
// Controller state machine that sequences clears, edge adds, builds and queries.
module tlca_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] operation,
	input tlca_pkg::flags_t flags,
	output tlca_pkg::cmd_t cmd,
	output logic busy
);
	import tlca_pkg::*;

	logic [UW-1:0] state_q, state_d;
	logic reply_q, reply_d;

	assign busy = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		reply_d = reply_q;
		cmd.uop = state_q;
		cmd.load = 1'b0;
		cmd.finish = 1'b0;
		cmd.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (operation)
						OP_CLEAR: begin
							state_d = S_HSWEEP;
							reply_d = 1'b1;
						end
						OP_ADD: state_d = S_E0;
						OP_BUILD: state_d = S_BCHK;
						default: state_d = S_Q0;
					endcase
				end
			end
			S_HSWEEP: begin
				if (flags.sweep_last) begin
					cmd.finish = reply_q;
					reply_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_E0: begin
				if (flags.a_zero || flags.b_zero) begin
					cmd.finish = 1'b1;
					cmd.status = ST_BAD_NODE;
					state_d = S_IDLE;
				end else if (flags.full) begin
					cmd.finish = 1'b1;
					cmd.status = ST_FULL;
					state_d = S_IDLE;
				end else begin
					state_d = S_E1;
				end
			end
			S_E1: state_d = S_E2;
			S_E2: state_d = S_E3;
			S_E3: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			S_BCHK: begin
				if (flags.a_zero) begin
					cmd.finish = 1'b1;
					cmd.status = ST_BAD_NODE;
					state_d = S_IDLE;
				end else begin
					state_d = S_BSWEEP;
				end
			end
			S_BSWEEP: if (flags.sweep_last) state_d = S_B1INIT;
			S_B1INIT: state_d = S_B1HEAD;
			S_B1HEAD: state_d = S_B1TOP;
			S_B1TOP: begin
				if (!flags.c_zero) state_d = S_B1EDGE;
				else if (flags.sp_one) state_d = S_B2INIT;
				else state_d = S_B1POP0;
			end
			S_B1EDGE: state_d = S_B1CHK;
			S_B1CHK: state_d = flags.fresh ? S_B1HEAD : S_B1TOP;
			S_B1POP0: state_d = S_B1POP1;
			S_B1POP1: state_d = S_B1POP2;
			S_B1POP2: state_d = S_B1POP3;
			S_B1POP3: state_d = S_B1TOP;
			S_B2INIT: state_d = S_B2HEAD;
			S_B2HEAD: state_d = S_B2TOP;
			S_B2TOP: begin
				if (!flags.c_zero) begin
					state_d = S_B2EDGE;
				end else if (flags.sp_one) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_B2POP0;
				end
			end
			S_B2EDGE: state_d = S_B2CHK;
			S_B2CHK: state_d = flags.p2_ok ? S_B2HEAD : S_B2TOP;
			S_B2POP0: state_d = S_B2POP1;
			S_B2POP1: state_d = S_B2POP2;
			S_B2POP2: state_d = S_B2TOP;
			S_Q0: begin
				if (!flags.built) begin
					cmd.finish = 1'b1;
					cmd.status = ST_NOT_BUILT;
					state_d = S_IDLE;
				end else if (flags.a_zero || flags.b_zero) begin
					cmd.finish = 1'b1;
					cmd.status = ST_BAD_NODE;
					state_d = S_IDLE;
				end else begin
					state_d = S_Q1;
				end
			end
			S_Q1: state_d = S_Q2;
			S_Q2: begin
				if (flags.depth_zero) begin
					cmd.finish = 1'b1;
					cmd.status = ST_BAD_NODE;
					state_d = S_IDLE;
				end else begin
					state_d = S_QL0;
				end
			end
			S_QL0: state_d = S_QL1;
			S_QL1: state_d = S_QL2;
			S_QL2: state_d = flags.same_chain ? S_QF0 : S_QL3;
			S_QL3: state_d = S_QL4;
			S_QL4: state_d = S_QL5;
			S_QL5: state_d = S_QL0;
			S_QF0: state_d = S_QF1;
			S_QF1: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register; reset starts with a pass that empties the edge lists.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HSWEEP;
			reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			reply_q <= reply_d;
		end
	end

	// A finished word always returns the controller to idle.
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == S_IDLE) else $error("finish not followed by idle");

	// A word is only taken in idle.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy) else $error("load while busy");

endmodule

FILE: design/tlca_dp.sv
// Datapath: edge store, node tables, walk stack and query registers.
module tlca_dp (
	input logic clk,
	input logic arst_n,
	input tlca_pkg::cmd_t cmd,
	input logic [9:0] node_a,
	input logic [9:0] node_b,
	output tlca_pkg::flags_t flags,
	output logic done,
	output logic [1:0] status,
	output logic [9:0] ancestor
);
	import tlca_pkg::*;

	// Memories.
	logic [LW-1:0] head_mem [NODE_SLOTS];
	logic [LW-1:0] next_mem [EDGE_SLOTS];
	logic [NW-1:0] tgt_mem [EDGE_SLOTS];
	logic [NW-1:0] par_mem [NODE_SLOTS];
	logic [NW-1:0] dep_mem [NODE_SLOTS];
	logic [NW-1:0] size_mem [NODE_SLOTS];
	logic [NW-1:0] heavy_mem [NODE_SLOTS];
	logic [NW-1:0] chain_mem [NODE_SLOTS];
	logic [NW-1:0] stkn_mem [NODE_SLOTS];
	logic [LW-1:0] stkc_mem [NODE_SLOTS];

	// Read data.
	logic [LW-1:0] head_rd, next_rd, stkc_rd;
	logic [NW-1:0] tgt_rd, par_rd, dep_rd, size_rd, heavy_rd, chain_rd, stkn_rd;

	// Ports.
	logic head_we, edge_we, par_we, dep_we, size_we, heavy_we, chain_we, stk_we;
	logic [NW-1:0] head_wa, head_ra, par_wa, par_ra, dep_wa, dep_ra;
	logic [NW-1:0] size_wa, size_ra, heavy_wa, heavy_ra, chain_wa, chain_ra;
	logic [NW-1:0] stk_wa, stk_ra;
	logic [EIW-1:0] edge_wa, edge_ra;
	logic [LW-1:0] head_wd, next_wd;
	logic [NW-1:0] tgt_wd, par_wd, dep_wd, size_wd, heavy_wd, chain_wd;

	// Registers.
	logic [NW-1:0] a_q, b_q, sw_q, p_q, sp_q, dp_q, t_q, szp_q, q_q;
	logic [NW-1:0] ch_q, u_q, v_q, da_q, hu_q, hv_q;
	logic [LW-1:0] c_q, cn_q, cnt_q;
	logic built_q, moveu_q, done_q;
	logic [1:0] status_q;
	logic [NW-1:0] anc_q;

	logic fresh, p2_ok, same_chain, hu_deeper;
	logic [NW-1:0] new_chain, anc_d;

	assign fresh = (dep_rd == '0);
	assign new_chain = (t_q == heavy_rd) ? ch_q : t_q;
	assign p2_ok = (par_rd == p_q) && (chain_rd == '0) && (t_q != a_q);
	assign same_chain = (hu_q == chain_rd);
	assign hu_deeper = (da_q > dep_rd);
	assign anc_d = (da_q > dep_rd) ? v_q : u_q;

	assign flags.a_zero = (a_q == '0);
	assign flags.b_zero = (b_q == '0);
	assign flags.full = (cnt_q > LW'(EDGE_SLOTS - 2));
	assign flags.built = built_q;
	assign flags.sweep_last = (sw_q == {NW{1'b1}});
	assign flags.c_zero = (c_q == '0);
	assign flags.sp_one = (sp_q == NW'(1));
	assign flags.fresh = fresh;
	assign flags.p2_ok = p2_ok;
	assign flags.depth_zero = (da_q == '0) || (dep_rd == '0);
	assign flags.same_chain = same_chain;

	// Memory address and write decode per step.
	always_comb begin
		head_we = 1'b0; head_wa = a_q; head_wd = LW'(cnt_q + LW'(1)); head_ra = a_q;
		edge_we = 1'b0; edge_wa = cnt_q[EIW-1:0]; edge_ra = EIW'(c_q - LW'(1));
		next_wd = head_rd; tgt_wd = b_q;
		par_we = 1'b0; par_wa = t_q; par_wd = p_q; par_ra = tgt_rd;
		dep_we = 1'b0; dep_wa = t_q; dep_wd = NW'(dp_q + NW'(1)); dep_ra = tgt_rd;
		size_we = 1'b0; size_wa = t_q; size_wd = NW'(1); size_ra = p_q;
		heavy_we = 1'b0; heavy_wa = q_q; heavy_wd = p_q; heavy_ra = stkn_rd;
		chain_we = 1'b0; chain_wa = t_q; chain_wd = new_chain; chain_ra = tgt_rd;
		stk_we = 1'b0; stk_wa = NW'(sp_q - NW'(1)); stk_ra = NW'(sp_q - NW'(2));
		case (cmd.uop)
			S_HSWEEP: begin
				head_we = 1'b1; head_wa = sw_q; head_wd = '0;
			end
			S_E1: begin
				head_we = 1'b1; edge_we = 1'b1;
			end
			S_E2: head_ra = b_q;
			S_E3: begin
				head_we = 1'b1; head_wa = b_q; edge_we = 1'b1; tgt_wd = a_q;
			end
			S_BSWEEP: begin
				dep_we = 1'b1; dep_wa = sw_q; dep_wd = '0;
				size_we = 1'b1; size_wa = sw_q; size_wd = '0;
				heavy_we = 1'b1; heavy_wa = sw_q; heavy_wd = '0;
				chain_we = 1'b1; chain_wa = sw_q; chain_wd = '0;
			end
			S_B1INIT: begin
				par_we = 1'b1; par_wa = a_q; par_wd = '0;
				dep_we = 1'b1; dep_wa = a_q; dep_wd = NW'(1);
				size_we = 1'b1; size_wa = a_q;
			end
			S_B1CHK: begin
				par_we = fresh; dep_we = fresh; size_we = fresh; stk_we = fresh;
				head_ra = t_q;
			end
			S_B1POP1: size_ra = stkn_rd;
			S_B1POP2: begin
				size_we = 1'b1; size_wa = q_q; size_wd = NW'(size_rd + szp_q);
				size_ra = heavy_rd;
			end
			S_B1POP3: heavy_we = (szp_q > size_rd);
			S_B2INIT: begin
				chain_we = 1'b1; chain_wa = a_q; chain_wd = a_q;
			end
			S_B2EDGE: heavy_ra = p_q;
			S_B2CHK: begin
				chain_we = p2_ok; stk_we = p2_ok; head_ra = t_q;
			end
			S_B2POP1: chain_ra = stkn_rd;
			S_Q0: dep_ra = a_q;
			S_Q1: dep_ra = b_q;
			S_QL0: chain_ra = u_q;
			S_QL1: chain_ra = v_q;
			S_QL2: dep_ra = same_chain ? u_q : hu_q;
			S_QL3: dep_ra = hv_q;
			S_QL4: par_ra = hu_deeper ? hu_q : hv_q;
			S_QF0: dep_ra = v_q;
			default: ;
		endcase
	end

	// Memory ports, read data registered.
	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd <= head_mem[head_ra];
		if (edge_we) begin
			next_mem[edge_wa] <= next_wd;
			tgt_mem[edge_wa] <= tgt_wd;
		end
		next_rd <= next_mem[edge_ra];
		tgt_rd <= tgt_mem[edge_ra];
		if (par_we) par_mem[par_wa] <= par_wd;
		par_rd <= par_mem[par_ra];
		if (dep_we) dep_mem[dep_wa] <= dep_wd;
		dep_rd <= dep_mem[dep_ra];
		if (size_we) size_mem[size_wa] <= size_wd;
		size_rd <= size_mem[size_ra];
		if (heavy_we) heavy_mem[heavy_wa] <= heavy_wd;
		heavy_rd <= heavy_mem[heavy_ra];
		if (chain_we) chain_mem[chain_wa] <= chain_wd;
		chain_rd <= chain_mem[chain_ra];
		if (stk_we) begin
			stkn_mem[stk_wa] <= p_q;
			stkc_mem[stk_wa] <= c_q;
		end
		stkn_rd <= stkn_mem[stk_ra];
		stkc_rd <= stkc_mem[stk_ra];
	end

	// Control registers: edge count, built mark, sweep address, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			built_q <= 1'b0;
			sw_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.uop == S_HSWEEP || cmd.uop == S_BSWEEP) sw_q <= NW'(sw_q + NW'(1));
			if (cmd.uop == S_HSWEEP) begin
				cnt_q <= '0;
				built_q <= 1'b0;
			end
			if (cmd.uop == S_E1 || cmd.uop == S_E3) cnt_q <= LW'(cnt_q + LW'(1));
			if (cmd.uop == S_E3) built_q <= 1'b0;
			if (cmd.uop == S_B2TOP && flags.c_zero && flags.sp_one) built_q <= 1'b1;
		end
	end

	// Walk and query working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= node_a;
			b_q <= node_b;
		end
		if (cmd.finish) begin
			status_q <= cmd.status;
			anc_q <= (cmd.uop == S_QF1) ? anc_d : '0;
		end
		case (cmd.uop)
			S_B1INIT: begin
				t_q <= a_q; sp_q <= '0; dp_q <= '0;
			end
			S_B2INIT: begin
				t_q <= a_q; sp_q <= '0; ch_q <= a_q;
			end
			S_B1HEAD: begin
				p_q <= t_q; c_q <= head_rd; sp_q <= NW'(sp_q + NW'(1));
				dp_q <= NW'(dp_q + NW'(1));
			end
			S_B2HEAD: begin
				p_q <= t_q; c_q <= head_rd; sp_q <= NW'(sp_q + NW'(1));
			end
			S_B1EDGE, S_B2EDGE: begin
				c_q <= next_rd; t_q <= tgt_rd;
			end
			S_B2CHK: if (p2_ok) ch_q <= new_chain;
			S_B1POP0, S_B2POP0: sp_q <= NW'(sp_q - NW'(1));
			S_B1POP1: begin
				q_q <= stkn_rd; cn_q <= stkc_rd; szp_q <= size_rd;
			end
			S_B1POP3: begin
				p_q <= q_q; c_q <= cn_q; dp_q <= NW'(dp_q - NW'(1));
			end
			S_B2POP1: begin
				p_q <= stkn_rd; c_q <= stkc_rd;
			end
			S_B2POP2: ch_q <= chain_rd;
			S_Q0: begin
				u_q <= a_q; v_q <= b_q;
			end
			S_Q1: da_q <= dep_rd;
			S_QL1: hu_q <= chain_rd;
			S_QL2: hv_q <= chain_rd;
			S_QL3: da_q <= dep_rd;
			S_QL4: moveu_q <= hu_deeper;
			S_QL5: begin
				if (moveu_q) u_q <= par_rd;
				else v_q <= par_rd;
			end
			S_QF0: da_q <= dep_rd;
			default: ;
		endcase
	end

	assign done = done_q;
	assign status = status_q;
	assign ancestor = anc_q;

	// The walk never looks at the top of an empty stack.
	a_sp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.uop == S_B1TOP || cmd.uop == S_B2TOP) |-> sp_q != '0)
		else $error("walk with empty stack");

	// The edge count never passes the store size.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LW'(EDGE_SLOTS)) else $error("edge count overflow");

	// A popped node always has a real parent.
	a_pop_parent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == S_B1POP3 |-> q_q != '0) else $error("pop to node zero");

	// An edge add stores its first entry only with both ends valid.
	a_edge_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == S_E1 |-> (a_q != '0 && b_q != '0)) else $error("bad edge end stored");

endmodule

FILE: design/tree_lca_heavy_light.sv
// Top level of the heavy-light lowest common ancestor block.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------
//  command | start, busy         | operation, node_a, node_b
//  result  | done (one cycle)    | status, ancestor
//
// One word is taken when start is high and busy is low; exactly one result
// follows, on the result ports for the single cycle that done is high.
// Edge add checks its ends and then stores two list entries; query reads both
// depths and then climbs one chain per round; clear sweeps every list head.
// Build first clears the node tables, then walks the tree twice, once for
// parents, depths, sizes and heavy children and once for chain tops;
// each walk step is bound by one registered read of the node memories.
// After reset, busy stays high for the pass that empties the edge lists. The
// receiver cannot stall; busy alone holds off the sender.
module tree_lca_heavy_light (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [9:0] node_a,
	input logic [9:0] node_b,
	output logic done,
	output logic [1:0] status,
	output logic [9:0] ancestor
);
	import tlca_pkg::*;

	cmd_t cmd;
	flags_t flags;

	tlca_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operation(operation),
		.flags(flags),
		.cmd(cmd),
		.busy(busy)
	);

	tlca_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.node_a(node_a),
		.node_b(node_b),
		.flags(flags),
		.done(done),
		.status(status),
		.ancestor(ancestor)
	);

endmodule

FILE: bench/tree_lca_heavy_light_tb.sv
// Self-checking testbench for the heavy-light lowest common ancestor block.
`timescale 1ns / 1ps
module tree_lca_heavy_light_tb;
	import tlca_pkg::*;

	localparam int RAND_WORDS = 500;
	localparam int STALL_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] operation = OP_CLEAR;
	logic [9:0] node_a = '0;
	logic [9:0] node_b = '0;
	logic done;
	logic [1:0] status;
	logic [9:0] ancestor;

	tree_lca_heavy_light uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .node_a(node_a), .node_b(node_b),
		.done(done), .status(status), .ancestor(ancestor)
	);

	always #2 clk = ~clk;

	typedef struct {
		logic [1:0] st;
		logic [9:0] anc;
	} answer_t;

	typedef struct {
		logic [1:0] op;
		logic [9:0] a;
		logic [9:0] b;
		logic known;
		logic [1:0] st;
		logic [9:0] anc;
	} row_t;

	// Predictor copy of the tree state.
	int unsigned lst_head[NODE_SLOTS];
	int unsigned lst_next[EDGE_SLOTS];
	int unsigned lst_tgt[EDGE_SLOTS];
	int unsigned entries;
	int unsigned par[NODE_SLOTS];
	int unsigned dep[NODE_SLOTS];
	int unsigned cnt[NODE_SLOTS];
	int unsigned heavy[NODE_SLOTS];
	int unsigned top[NODE_SLOTS];
	int unsigned stk_n[NODE_SLOTS];
	int unsigned stk_c[NODE_SLOTS];
	bit built;

	answer_t pending[$];
	int errors = 0;
	int quiet = 0;
	bit calm = 1'b0;

	function automatic bit valid_node(logic [9:0] x);
		return x != 0 && x < NODE_SLOTS;
	endfunction

	function automatic void wipe_nodes();
		for (int i = 0; i < NODE_SLOTS; i++) begin
			par[i] = 0; dep[i] = 0; cnt[i] = 0; heavy[i] = 0; top[i] = 0;
		end
	endfunction

	function automatic void link(int unsigned f, int unsigned t);
		lst_tgt[entries] = t;
		lst_next[entries] = lst_head[f];
		lst_head[f] = entries + 1;
		entries++;
	endfunction

	function automatic void build_tree(int unsigned r);
		int unsigned sp, p, c, t, q;
		wipe_nodes();
		dep[r] = 1; cnt[r] = 1;
		stk_n[0] = r; stk_c[0] = lst_head[r]; sp = 1;
		while (sp > 0) begin
			p = stk_n[sp-1]; c = stk_c[sp-1];
			if (c == 0 || c > EDGE_SLOTS) begin
				sp--;
				if (sp > 0) begin
					q = par[p];
					cnt[q] += cnt[p];
					if (cnt[p] > cnt[heavy[q]]) heavy[q] = p;
				end
			end else begin
				stk_c[sp-1] = lst_next[c-1];
				t = lst_tgt[c-1];
				if (t < NODE_SLOTS && dep[t] == 0 && sp < NODE_SLOTS) begin
					par[t] = p; dep[t] = dep[p] + 1; cnt[t] = 1; heavy[t] = 0;
					stk_n[sp] = t; stk_c[sp] = lst_head[t]; sp++;
				end
			end
		end
		// Second walk assigns chain tops.
		top[r] = r;
		stk_n[0] = r; stk_c[0] = lst_head[r]; sp = 1;
		while (sp > 0) begin
			p = stk_n[sp-1]; c = stk_c[sp-1];
			if (c == 0 || c > EDGE_SLOTS) begin
				sp--;
			end else begin
				stk_c[sp-1] = lst_next[c-1];
				t = lst_tgt[c-1];
				if (t < NODE_SLOTS && par[t] == p && top[t] == 0 && t != r
						&& sp < NODE_SLOTS) begin
					top[t] = (t == heavy[p]) ? top[p] : t;
					stk_n[sp] = t; stk_c[sp] = lst_head[t]; sp++;
				end
			end
		end
		built = 1'b1;
	endfunction

	function automatic int unsigned lca_of(int unsigned u, int unsigned v);
		int unsigned guard = 0;
		while (top[u] != top[v] && guard < 2 * NODE_SLOTS) begin
			if (dep[top[u]] > dep[top[v]]) u = par[top[u]];
			else v = par[top[v]];
			guard++;
		end
		return dep[u] > dep[v] ? v : u;
	endfunction

	function automatic answer_t predict_answer(logic [1:0] op, logic [9:0] a,
			logic [9:0] b);
		answer_t r;
		r.st = ST_OK; r.anc = '0;
		case (op)
			OP_CLEAR: begin
				for (int i = 0; i < NODE_SLOTS; i++) lst_head[i] = 0;
				entries = 0; wipe_nodes(); built = 1'b0;
			end
			OP_ADD: begin
				if (!valid_node(a) || !valid_node(b)) r.st = ST_BAD_NODE;
				else if (entries + 2 > EDGE_SLOTS) r.st = ST_FULL;
				else begin
					link(32'(a), 32'(b)); link(32'(b), 32'(a)); built = 1'b0;
				end
			end
			OP_BUILD: begin
				if (!valid_node(a)) r.st = ST_BAD_NODE;
				else build_tree(32'(a));
			end
			default: begin
				if (!built) r.st = ST_NOT_BUILT;
				else if (!valid_node(a) || !valid_node(b) || dep[a] == 0 || dep[b] == 0)
					r.st = ST_BAD_NODE;
				else r.anc = 10'(lca_of(32'(a), 32'(b)));
			end
		endcase
		return r;
	endfunction

	// Sender: hold start until the word is taken, with random gaps.
	task automatic send_word(logic [1:0] op, logic [9:0] a, logic [9:0] b,
			output answer_t ans);
		while (!calm && $urandom_range(99) < 23) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1; operation <= op; node_a <= a; node_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		ans = predict_answer(op, a, b);
		pending.insert(pending.size(), ans);
	endtask

	// Stop sending and wait until every expected result has come.
	task automatic drain();
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
	endtask

	// Result checker.
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$error("unexpected result word status=%0d ancestor=%0d", status, ancestor);
				errors++;
			end else begin
				e = pending.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, status);
					errors++;
				end
				if (ancestor !== e.anc) begin
					$error("ancestor: expected %0d, actual %0d", e.anc, ancestor);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without progress.
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("tree_lca_heavy_light_tb failed");
			$finish;
		end
	end

	row_t rows[$];
	int unsigned tree_n;

	task automatic add_row(logic [1:0] op, logic [9:0] a, logic [9:0] b,
			logic known, logic [1:0] st, logic [9:0] anc);
		row_t r;
		r.op = op; r.a = a; r.b = b; r.known = known; r.st = st; r.anc = anc;
		rows.insert(rows.size(), r);
	endtask

	// Random node: mostly within the current tree size, now and then any 10-bit value.
	function automatic logic [9:0] pick_node();
		if ($urandom_range(99) < 3) return 10'($urandom_range(1023));
		return 10'($urandom_range(tree_n, 1));
	endfunction

	initial begin
		answer_t ans;
		int unsigned n, k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table.
		add_row(OP_QUERY, 10'd1, 10'd2, 1'b1, ST_NOT_BUILT, 10'd0);
		add_row(OP_ADD, 10'd0, 10'd5, 1'b1, ST_BAD_NODE, 10'd0);
		add_row(OP_ADD, 10'd5, 10'd0, 1'b1, ST_BAD_NODE, 10'd0);
		add_row(OP_BUILD, 10'd0, 10'd0, 1'b1, ST_BAD_NODE, 10'd0);
		add_row(OP_ADD, 10'd1, 10'd2, 1'b1, ST_OK, 10'd0);
		add_row(OP_ADD, 10'd1, 10'd1023, 1'b1, ST_OK, 10'd0);
		add_row(OP_ADD, 10'd2, 10'd3, 1'b1, ST_OK, 10'd0);
		add_row(OP_ADD, 10'd3, 10'd3, 1'b1, ST_OK, 10'd0);
		add_row(OP_ADD, 10'd2, 10'd3, 1'b1, ST_OK, 10'd0);
		add_row(OP_QUERY, 10'd1, 10'd2, 1'b1, ST_NOT_BUILT, 10'd0);
		add_row(OP_BUILD, 10'd1, 10'd1023, 1'b1, ST_OK, 10'd0);
		add_row(OP_QUERY, 10'd3, 10'd1023, 1'b1, ST_OK, 10'd1);
		add_row(OP_QUERY, 10'd3, 10'd2, 1'b1, ST_OK, 10'd2);
		add_row(OP_QUERY, 10'd1023, 10'd1023, 1'b1, ST_OK, 10'd1023);
		add_row(OP_QUERY, 10'd0, 10'd2, 1'b1, ST_BAD_NODE, 10'd0);
		add_row(OP_QUERY, 10'd2, 10'd700, 1'b1, ST_BAD_NODE, 10'd0);
		add_row(OP_BUILD, 10'd700, 10'd3, 1'b1, ST_OK, 10'd0);
		add_row(OP_QUERY, 10'd700, 10'd700, 1'b1, ST_OK, 10'd700);
		add_row(OP_QUERY, 10'd1, 10'd2, 1'b1, ST_BAD_NODE, 10'd0);
		add_row(OP_BUILD, 10'd1023, 10'd0, 1'b0, ST_OK, 10'd0);
		add_row(OP_QUERY, 10'd3, 10'd1, 1'b0, ST_OK, 10'd0);
		add_row(OP_CLEAR, 10'd1023, 10'd1023, 1'b1, ST_OK, 10'd0);
		add_row(OP_QUERY, 10'd1, 10'd1, 1'b1, ST_NOT_BUILT, 10'd0);
		foreach (rows[i]) begin
			send_word(rows[i].op, rows[i].a, rows[i].b, ans);
			if (rows[i].known && (ans.st !== rows[i].st || ans.anc !== rows[i].anc)) begin
				$error("table row %0d: predictor gives %0d/%0d", i, ans.st, ans.anc);
				errors++;
			end
		end
		drain();

		// Fill the edge store to overflow once.
		for (int i = 0; i < NODE_SLOTS + 1; i++)
			send_word(OP_ADD, 10'(1 + i % 1023), 10'(1 + (i * 7) % 1023), ans);
		send_word(OP_BUILD, 10'd1, 10'd0, ans);
		send_word(OP_QUERY, 10'd1023, 10'd500, ans);
		send_word(OP_QUERY, 10'd17, 10'd900, ans);

		// Random trees: small random trees, build, then queries; some noise.
		k = 0;
		while (k < RAND_WORDS) begin
			calm = (k > 150 && k < 350);
			send_word(OP_CLEAR, 10'($urandom), 10'($urandom), ans); k++;
			tree_n = (($urandom_range(19) == 0) ? $urandom_range(200, 2) :
				$urandom_range(24, 2));
			n = tree_n;
			for (int v = 2; v <= n; v++) begin
				if ($urandom_range(19) == 0)
					send_word(OP_ADD, pick_node(), pick_node(), ans);
				else
					send_word(OP_ADD, 10'(v), 10'($urandom_range(v - 1, 1)), ans);
				k++;
			end
			if ($urandom_range(9) == 0) begin
				send_word(OP_QUERY, pick_node(), pick_node(), ans); k++;
			end
			send_word(OP_BUILD, ($urandom_range(9) == 0) ? pick_node() :
				10'($urandom_range(n, 1)), 10'($urandom), ans);
			k++;
			repeat ($urandom_range(12, 3)) begin
				send_word(OP_QUERY, pick_node(), pick_node(), ans); k++;
			end
			if (k > 300 && k < 340) drain();
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0) $display("tree_lca_heavy_light_tb passed");
		else $display("tree_lca_heavy_light_tb failed");
		$finish;
	end
endmodule

FILE: sim.f
design/tlca_pkg.sv
design/tlca_ctrl.sv
design/tlca_dp.sv
design/tree_lca_heavy_light.sv
bench/tree_lca_heavy_light_tb.sv
